/* hw/rtl/csfw_pkg.sv */
package csfw_pkg;

	// default sizing, handed down through the top level
	localparam int NUM_RESOURCES_DEF = 16;
	localparam int QUEUE_SLOTS_DEF   = 8;

	// fixed field widths
	localparam int ID_W    = 8;
	localparam int ID_SPAN = 1 << ID_W;
	localparam int PID_W   = 8;
	localparam int UNITS_W = 16;
	localparam int AVAIL_W = 15;
	localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;

	// request codes
	typedef logic [1:0] req_type_t;
	localparam req_type_t REQ_CREATE  = 2'd0;
	localparam req_type_t REQ_REQUEST = 2'd1;
	localparam req_type_t REQ_RELEASE = 2'd2;

	// result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_NOT_FOUND  = 3'd1;
	localparam status_t ST_TABLE_FULL = 3'd2;
	localparam status_t ST_QUEUED     = 3'd3;
	localparam status_t ST_QUEUE_FULL = 3'd4;

endpackage

/* hw/rtl/csfw_req_if.sv */
interface csfw_req_if;
	import csfw_pkg::*;

	logic                      valid;
	logic                      ready;
	req_type_t                 req_type;
	logic [ID_W-1:0]           res_id;
	logic [PID_W-1:0]          pid;
	logic signed [UNITS_W-1:0] units;

	modport source (output valid, output req_type, output res_id, output pid,
		output units, input ready);
	modport sink (input valid, input req_type, input res_id, input pid,
		input units, output ready);
endinterface

/* hw/rtl/csfw_rsp_if.sv */
interface csfw_rsp_if;
	import csfw_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic             woken_valid;
	logic [PID_W-1:0] woken_pid;

	modport source (output valid, output status, output woken_valid,
		output woken_pid, input ready);
	modport sink (input valid, input status, input woken_valid,
		input woken_pid, output ready);
endinterface

/* hw/rtl/counting_semaphore_fifo_waiters.sv */
// Table of counting semaphores with FIFO wait queues.
// req channel (valid/ready): one beat per operation: create, request or release
// of a resource id, with pid (request) and starting units (create).
// rsp channel (valid/ready): exactly one beat per request beat, in order,
// carrying status and, for a release that woke a waiter, the woken pid.
// The block works on one operation at a time. An id lookup goes through a
// per-id index map (one memory read), then the entry memory (one read), and
// a release that wakes a waiter also reads the wait-ring memory.
// After the accept, the lookup state settles a create or an unknown id, the
// entry state settles a request and a release without waiters, and the ring
// state settles a release that wakes a waiter. The next beat can be taken in
// the cycle after the result is registered.
// A result sits in the output register while the receiver stalls; the block
// still takes the next request and holds its own result until the register
// frees up.
// Reset empties the table (id valid bits and entry count clear at once);
// the memories need no clearing pass.
module counting_semaphore_fifo_waiters #(
	parameter int NUM_RESOURCES = csfw_pkg::NUM_RESOURCES_DEF,
	parameter int QUEUE_SLOTS   = csfw_pkg::QUEUE_SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	csfw_req_if.sink   req,
	csfw_rsp_if.source rsp
);
	import csfw_pkg::*;

	localparam int IDX_W      = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int CNT_W      = $clog2(NUM_RESOURCES + 1);
	localparam int PTR_W      = $clog2(QUEUE_SLOTS);
	localparam int ENT_W      = AVAIL_W + 2 * PTR_W;
	localparam int RING_DEPTH = NUM_RESOURCES * QUEUE_SLOTS;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_ENT  = 4'b0100,
		S_RING = 4'b1000
	} state_t;

	// ring pointer increment, wrapping at QUEUE_SLOTS
	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t state_q, state_d;

	// latched request
	req_type_t                 req_type_q;
	logic [ID_W-1:0]           res_id_q;
	logic [PID_W-1:0]          pid_q;
	logic signed [UNITS_W-1:0] units_q;

	// table bookkeeping
	logic [CNT_W-1:0]   count_q;
	logic [ID_SPAN-1:0] id_valid_q;

	// memories and their registered read data
	logic [IDX_W-1:0] map_mem [ID_SPAN];
	logic [ENT_W-1:0] ent_mem [NUM_RESOURCES];
	logic [PID_W-1:0] ring_mem [RING_DEPTH];
	logic [IDX_W-1:0] map_rdata_q;
	logic [ENT_W-1:0] ent_rdata_q;
	logic [PID_W-1:0] ring_rdata_q;

	// output register
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_wv_q;
	logic [PID_W-1:0] out_wp_q;

	// control
	logic             in_beat, slot_free;
	logic             map_we, ent_we, ent_re, ring_we, ring_re;
	logic [IDX_W-1:0] ent_waddr;
	logic [ENT_W-1:0] ent_wdata;
	logic [PTR_W-1:0] ring_ptr;
	logic [RING_AW-1:0] ring_addr;
	logic             emit, cnt_inc;
	status_t          st_d;
	logic             wv_d;
	logic [PID_W-1:0] wp_d;

	// fields of the entry just read
	logic [AVAIL_W-1:0] e_avail;
	logic [PTR_W-1:0]   e_head, e_tail, e_tail_nx, e_head_nx;
	logic [AVAIL_W-1:0] clamp_units;

	assign in_beat   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || rsp.ready;

	assign e_avail   = ent_rdata_q[ENT_W-1 -: AVAIL_W];
	assign e_head    = ent_rdata_q[2*PTR_W-1 -: PTR_W];
	assign e_tail    = ent_rdata_q[PTR_W-1:0];
	assign e_tail_nx = ring_next(e_tail);
	assign e_head_nx = ring_next(e_head);

	// negative starting count becomes zero
	assign clamp_units = units_q[UNITS_W-1] ? '0 : units_q[AVAIL_W-1:0];

	assign ring_addr = RING_AW'(RING_AW'(map_rdata_q) * RING_AW'(QUEUE_SLOTS))
		+ RING_AW'(ring_ptr);

	// sequencer: lookup, entry read-modify-write, ring access
	always_comb begin
		state_d   = state_q;
		map_we    = 1'b0;
		ent_we    = 1'b0;
		ent_re    = 1'b0;
		ent_waddr = map_rdata_q;
		ent_wdata = ent_rdata_q;
		ring_we   = 1'b0;
		ring_re   = 1'b0;
		ring_ptr  = e_tail;
		emit      = 1'b0;
		cnt_inc   = 1'b0;
		st_d      = ST_OK;
		wv_d      = 1'b0;
		wp_d      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_LOOK;
			end
			S_LOOK: begin
				if (req_type_q == REQ_CREATE) begin
					if (slot_free) begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (count_q >= CNT_W'(NUM_RESOURCES)) begin
							st_d = ST_TABLE_FULL;
						end else begin
							ent_we    = 1'b1;
							ent_waddr = count_q[IDX_W-1:0];
							ent_wdata = {clamp_units, {(2*PTR_W){1'b0}}};
							cnt_inc   = 1'b1;
							// first entry with this id wins later lookups
							map_we    = !id_valid_q[res_id_q];
						end
					end
				end else if ((req_type_q == REQ_REQUEST || req_type_q == REQ_RELEASE)
						&& id_valid_q[res_id_q]) begin
					ent_re  = 1'b1;
					state_d = S_ENT;
				end else if (slot_free) begin
					emit    = 1'b1;
					st_d    = ST_NOT_FOUND;
					state_d = S_IDLE;
				end
			end
			S_ENT: begin
				if (req_type_q == REQ_REQUEST) begin
					if (slot_free) begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (e_avail != '0) begin
							ent_we    = 1'b1;
							ent_wdata = {e_avail - 1'b1, e_head, e_tail};
						end else if (e_tail_nx == e_head) begin
							st_d = ST_QUEUE_FULL;
						end else begin
							ring_we   = 1'b1;
							ent_we    = 1'b1;
							ent_wdata = {e_avail, e_head, e_tail_nx};
							st_d      = ST_QUEUED;
						end
					end
				end else if (e_head != e_tail) begin
					// wake the oldest waiter
					ring_re   = 1'b1;
					ring_ptr  = e_head;
					ent_we    = 1'b1;
					ent_wdata = {e_avail, e_head_nx, e_tail};
					state_d   = S_RING;
				end else if (slot_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (e_avail != AVAIL_MAX) begin
						ent_we    = 1'b1;
						ent_wdata = {e_avail + 1'b1, e_head, e_tail};
					end
				end
			end
			S_RING: begin
				if (slot_free) begin
					emit    = 1'b1;
					wv_d    = 1'b1;
					wp_d    = ring_rdata_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			id_valid_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) count_q <= count_q + 1'b1;
			if (map_we) id_valid_q[res_id_q] <= 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			req_type_q <= req.req_type;
			res_id_q   <= req.res_id;
			pid_q      <= req.pid;
			units_q    <= req.units;
		end
		if (emit) begin
			out_status_q <= st_d;
			out_wv_q     <= wv_d;
			out_wp_q     <= wp_d;
		end
	end

	// id to entry index map
	always_ff @(posedge clk) begin
		if (map_we) map_mem[res_id_q] <= count_q[IDX_W-1:0];
		if (in_beat) map_rdata_q <= map_mem[req.res_id];
	end

	// entry memory: units, ring head and tail
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		if (ent_re) ent_rdata_q <= ent_mem[map_rdata_q];
	end

	// wait rings, one row of QUEUE_SLOTS per entry
	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[ring_addr] <= pid_q;
		if (ring_re) ring_rdata_q <= ring_mem[ring_addr];
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.woken_valid = out_wv_q;
	assign rsp.woken_pid   = out_wp_q;

endmodule

/* hw/rtl/csfw_checker.sv */
module csfw_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input csfw_pkg::status_t         status,
	input logic                      woken_valid,
	input logic [csfw_pkg::PID_W-1:0] woken_pid
);
	import csfw_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({status, woken_valid, woken_pid}))
		else $error("result beat changed while stalled");

	// one operation in flight: no beat right after an accepted one
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an operation is in flight");

	// waking a waiter is only a successful release
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && woken_valid |-> status == ST_OK)
		else $error("woken pid with non-ok status");

	// no wake means a zero pid
	a_wake_pid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !woken_valid |-> woken_pid == '0)
		else $error("woken pid set without a wake");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker u_csfw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.woken_valid (rsp.woken_valid),
	.woken_pid   (rsp.woken_pid)
);
